### rtl/core/qdd_pkg.sv
`default_nettype none

package qdd_pkg;

	// Timestamp bits that take part in the debounce arithmetic.
	localparam int TIME_BITS = 32;
	localparam int DEB_BITS  = 16;
	localparam int CMP_BITS  = (TIME_BITS > DEB_BITS) ? TIME_BITS : DEB_BITS;
	localparam int STEP_BITS = 4;
	localparam int ACC_BITS  = 5;

	localparam logic [STEP_BITS-1:0] DETENT_RESET   = 4'd4;
	localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET = 16'd20;

	typedef enum logic [0:0] {
		CFG_DETENT   = 1'b0,
		CFG_DEBOUNCE = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_CW   = 2'd1,
		ROT_CCW  = 2'd2
	} rot_t;

	typedef enum logic [1:0] {
		BTN_NONE    = 2'd0,
		BTN_PRESS   = 2'd1,
		BTN_RELEASE = 2'd2
	} btn_t;

	typedef struct packed {
		logic        enc_a;
		logic        enc_b;
		logic        switch_level;
		logic [31:0] now_ms;
	} poll_t;

	typedef struct packed {
		rot_t rotation;
		btn_t button_event;
		logic button_released;
	} report_t;

	// Step per (previous AB, current AB) pair, previous in the upper two index bits.
	localparam logic signed [1:0] QUAD_STEPS [16] = '{
		 2'sd0, -2'sd1,  2'sd1,  2'sd0,
		 2'sd1,  2'sd0,  2'sd0, -2'sd1,
		-2'sd1,  2'sd0,  2'sd0,  2'sd1,
		 2'sd0,  2'sd1, -2'sd1,  2'sd0
	};

endpackage

`default_nettype wire

### rtl/core/quadrature_detent_decoder_unit.sv
`default_nettype none

// Channel   Direction  Handshake             Word
// poll      in         poll_valid/stall      poll_word   (A, B, switch, ms stamp)
// report    out        report_valid/stall    report_word (detent, button, level)
// cfg       in         cfg_valid/ready       cfg_index, cfg_data
//
// One word per cycle while reports are not stalled; report valid rises once
// an accepted poll word has passed the input register and then the result
// register.
// The per-word decode, accumulate and debounce update is one pass of logic
// between the input register and the result register, so the state updated
// by one word is already in place for the next word.
// Reset: AB = 11, switch raw and stable released, accumulator and change
// stamp zero, detent_steps 4, debounce_time 20.
// A stalled report holds the result word and any held input word; poll_stall
// rises only when the input register is full and cannot move forward.

module quadrature_detent_decoder_unit import qdd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                poll_valid,
	output logic                     poll_stall,
	input  wire poll_t               poll_word,
	output logic                     report_valid,
	input  wire logic                report_stall,
	output report_t                  report_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire cfg_idx_t            cfg_index,
	input  wire logic [DEB_BITS-1:0] cfg_data
);

	logic [STEP_BITS-1:0] detent_steps_q;
	logic [DEB_BITS-1:0]  debounce_time_q;

	logic    valid_s1;
	poll_t   poll_s1;
	logic    valid_s2;
	report_t report_s2;

	logic    advance;
	logic    fire;
	logic    poll_take;
	rot_t    rotation;
	btn_t    button_event;
	logic    stable_d;

	// Config writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detent_steps_q  <= DETENT_RESET;
			debounce_time_q <= DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DETENT:   detent_steps_q  <= cfg_data[STEP_BITS-1:0];
				CFG_DEBOUNCE: debounce_time_q <= cfg_data;
			endcase
		end
	end

	// Advance the input word when the result register is empty or draining.
	assign advance    = !valid_s2 || !report_stall;
	assign fire       = valid_s1 && advance;
	assign poll_stall = valid_s1 && !advance;
	assign poll_take  = poll_valid && !poll_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_take) begin
			poll_s1 <= poll_word;
		end
	end

	// Rotation path: transition table, accumulator, detent threshold.
	qdd_rot u_rot (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (fire),
		.enc_a        (poll_s1.enc_a),
		.enc_b        (poll_s1.enc_b),
		.detent_steps (detent_steps_q),
		.rotation     (rotation)
	);

	// Switch path: raw edge stamp and hold-time check.
	qdd_btn u_btn (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (fire),
		.switch_level  (poll_s1.switch_level),
		.now           (poll_s1.now_ms[TIME_BITS-1:0]),
		.debounce_time (debounce_time_q),
		.button_event  (button_event),
		.stable_d      (stable_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			report_s2.rotation        <= rotation;
			report_s2.button_event    <= button_event;
			report_s2.button_released <= stable_d;
		end
	end

	assign report_valid = valid_s2;
	assign report_word  = report_s2;

	// A press report must carry a pressed level, a release a released level.
	a_btn_level: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && (report_word.button_event == BTN_PRESS)
			|-> !report_word.button_released)
		else $error("press reported with released level");

	a_rel_level: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && (report_word.button_event == BTN_RELEASE)
			|-> report_word.button_released)
		else $error("release reported with pressed level");

	// A held input word is never dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input word lost while blocked");

	// A word that moves forward always shows up in the result register.
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed word missing from result register");

endmodule

`default_nettype wire

### rtl/core/qdd_rot.sv
`default_nettype none

module qdd_rot import qdd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 enc_a,
	input  wire logic                 enc_b,
	input  wire logic [STEP_BITS-1:0] detent_steps,
	output rot_t                      rotation
);

	logic [1:0]                 last_ab_q;
	logic signed [ACC_BITS-1:0] accum_q;

	logic [1:0]                 cur_ab;
	logic signed [1:0]          delta;
	logic signed [ACC_BITS-1:0] sum;
	logic signed [ACC_BITS-1:0] thr;
	logic signed [ACC_BITS-1:0] accum_d;

	always_comb begin
		cur_ab = {enc_a, enc_b};
		delta  = (cur_ab != last_ab_q) ? QUAD_STEPS[{last_ab_q, cur_ab}] : 2'sd0;
		sum    = accum_q + ACC_BITS'(delta);
		// zero threshold acts as one
		thr    = (detent_steps == '0) ? ACC_BITS'(1)
		                              : $signed({1'b0, detent_steps});
		if (sum >= thr) begin
			rotation = ROT_CW;
			accum_d  = sum - thr;
		end else if (sum <= -thr) begin
			rotation = ROT_CCW;
			accum_d  = sum + thr;
		end else begin
			rotation = ROT_NONE;
			accum_d  = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ab_q <= 2'b11;
			accum_q   <= '0;
		end else if (en) begin
			last_ab_q <= cur_ab;
			accum_q   <= accum_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/qdd_btn.sv
`default_nettype none

module qdd_btn import qdd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 switch_level,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic [DEB_BITS-1:0]  debounce_time,
	output btn_t                      button_event,
	output logic                      stable_d
);

	logic                 raw_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] chg_q;

	logic [TIME_BITS-1:0] chg_d;
	logic [TIME_BITS-1:0] elapsed;
	logic                 settle;

	always_comb begin
		// restart the hold window on every raw edge
		chg_d   = (switch_level != raw_q) ? now : chg_q;
		elapsed = now - chg_d;
		settle  = (switch_level != stable_q) &&
		          (CMP_BITS'(elapsed) >= CMP_BITS'(debounce_time));
		stable_d = settle ? switch_level : stable_q;
		if (settle) begin
			button_event = switch_level ? BTN_RELEASE : BTN_PRESS;
		end else begin
			button_event = BTN_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b1;
			stable_q <= 1'b1;
			chg_q    <= '0;
		end else if (en) begin
			raw_q    <= switch_level;
			stable_q <= stable_d;
			chg_q    <= chg_d;
		end
	end

endmodule

`default_nettype wire

### bench/quadrature_detent_decoder_unit_tb.sv
module quadrature_detent_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qdd_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int ITEMS_PER_PASS = 200;
	localparam int PASS_COUNT     = 8;
	localparam int SHOW_LIMIT     = 10;

	// Per-pass settings: detent size, debounce ms, idling mode.
	// Modes: 0 no idling, 1 sender idles, 2 receiver stalls, 3 both lightly.
	localparam int PASS_DETENT   [PASS_COUNT] = '{15, 1, 0, 7, 3, 15, 2, 4};
	localparam int PASS_DEBOUNCE [PASS_COUNT] = '{65535, 0, 3, 300, 1, 40, 12000, 20};
	localparam int PASS_MODE     [PASS_COUNT] = '{0, 1, 2, 3, 1, 0, 3, 2};

	typedef struct {
		poll_t   word;
		bit      typed;
		report_t rep;
	} poll_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        poll_valid = 1'b0;
	logic        poll_stall;
	poll_t       poll_word = '0;
	logic        report_valid;
	logic        report_stall = 1'b0;
	report_t     report_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_DETENT;
	logic [15:0] cfg_data = '0;

	// Hand-typed expectation that travels along with the poll word.
	bit          poll_typed = 1'b0;
	report_t     poll_typed_rep = '0;

	int          send_pct = 0;
	int          stall_pct = 0;
	int          error_count = 0;
	int          cycle_count = 0;

	report_t     pending_reports [$];
	poll_row_t   directed_rows [$];

	// Tracked copy of the decoder: settings and state as they stand after reset.
	logic [3:0]  cur_detent = DETENT_RESET;
	logic [15:0] cur_debounce = DEBOUNCE_RESET;
	logic [1:0]  trk_ab = 2'b11;
	int          trk_accum = 0;
	logic        trk_sw_raw = 1'b1;
	logic        trk_sw_stable = 1'b1;
	logic [31:0] trk_sw_stamp = '0;

	// Generator state for the random polls.
	logic [1:0]  stim_ab = 2'b11;
	logic        stim_sw = 1'b1;
	logic [31:0] stim_now = '0;
	bit          stim_cw = 1'b1;
	int          stim_deb = 20;

	quadrature_detent_decoder_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_stall   (poll_stall),
		.poll_word    (poll_word),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report_word  (report_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Position of an AB level pair along the clockwise Gray cycle 00-10-11-01.
	function automatic logic [1:0] gray_pos(input logic [1:0] ab);
		return {ab[0], ab[1] ^ ab[0]};
	endfunction

	function automatic logic [1:0] gray_ab(input logic [1:0] pos);
		return {pos[1] ^ pos[0], pos[1]};
	endfunction

	// Advance the tracked decoder by one poll word and return its report.
	function automatic report_t decode_poll(input poll_t w);
		report_t     r;
		logic [1:0]  cur_ab;
		logic [1:0]  turn;
		logic [31:0] elapsed;
		int          thr;
		r = '{ROT_NONE, BTN_NONE, 1'b0};
		cur_ab = {w.enc_a, w.enc_b};
		// a zero detent setting behaves as one transition per click
		thr = (cur_detent == 4'd0) ? 1 : int'(cur_detent);
		if (cur_ab != trk_ab) begin
			// one step forward or back counts; a jump across the cycle counts nothing
			turn = gray_pos(cur_ab) - gray_pos(trk_ab);
			if (turn == 2'd1)
				trk_accum++;
			else if (turn == 2'd3)
				trk_accum--;
			trk_ab = cur_ab;
		end
		// at most one click per word, so leftover count drains one click at a time
		if (trk_accum >= thr) begin
			r.rotation = ROT_CW;
			trk_accum -= thr;
		end else if (trk_accum <= -thr) begin
			r.rotation = ROT_CCW;
			trk_accum += thr;
		end
		if (w.switch_level != trk_sw_raw) begin
			trk_sw_raw = w.switch_level;
			trk_sw_stamp = w.now_ms;
		end
		elapsed = w.now_ms - trk_sw_stamp;
		if (trk_sw_raw != trk_sw_stable && elapsed >= {16'd0, cur_debounce}) begin
			trk_sw_stable = trk_sw_raw;
			r.button_event = trk_sw_stable ? BTN_RELEASE : BTN_PRESS;
		end
		r.button_released = trk_sw_stable;
		return r;
	endfunction

	// Mostly clean rotation runs with occasional reversals, skipped states
	// and noise; the switch toggles now and then, time creeps forward with rare random jumps.
	function automatic poll_t next_poll();
		poll_t       w;
		int unsigned pick;
		if ($urandom_range(0, 99) < 8)
			stim_cw = !stim_cw;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			stim_ab = gray_ab(gray_pos(stim_ab) + (stim_cw ? 2'd1 : 2'd3));
		else if (pick < 75)
			stim_ab = stim_ab ^ 2'b11;
		else if (pick < 79)
			stim_ab = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 6)
			stim_sw = !stim_sw;
		if ($urandom_range(0, 99) < 2)
			stim_now = $urandom;
		else
			stim_now = stim_now + $urandom_range(0, stim_deb / 3 + 2);
		w.enc_a = stim_ab[1];
		w.enc_b = stim_ab[0];
		w.switch_level = stim_sw;
		w.now_ms = stim_now;
		return w;
	endfunction

	task automatic add_row(input logic a, input logic b, input logic sw, input logic [31:0] ms,
			input bit typed, input rot_t rot = ROT_NONE, input btn_t btn = BTN_NONE,
			input logic rel = 1'b1);
		poll_row_t row;
		row.word = '{a, b, sw, ms};
		row.typed = typed;
		row.rep = '{rot, btn, rel};
		directed_rows.push_back(row);
	endtask

	task automatic report_error(input string what, input int want, input int got);
		error_count++;
		if (error_count <= SHOW_LIMIT)
			$display("%0t: report %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Offer one poll word; idle first at the sender's rate. Valid stays high
	// after acceptance so back-to-back words do not need it to drop and rise again.
	task automatic send_poll(input poll_t w, input bit typed, input report_t rep);
		while ($urandom_range(0, 99) < send_pct) begin
			poll_valid <= 1'b0;
			@(posedge clk);
		end
		poll_valid <= 1'b1;
		poll_word <= w;
		poll_typed <= typed;
		poll_typed_rep <= rep;
		do @(posedge clk); while (poll_stall);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Hold until every expected report is back, then let the pipe settle.
	task automatic drain_reports();
		do @(posedge clk); while (pending_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk)
		report_stall <= ($urandom_range(0, 99) < stall_pct);

	// Track register writes, predict each accepted poll, check each report.
	always @(posedge clk) begin
		report_t want;
		report_t got;
		report_t pred;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_DETENT: begin
					cur_detent = cfg_data[3:0];
				end
				CFG_DEBOUNCE: begin
					cur_debounce = cfg_data;
				end
				default: begin
				end
				endcase
			end
			if (poll_valid && !poll_stall) begin
				pred = decode_poll(poll_word);
				pending_reports.push_back(poll_typed ? poll_typed_rep : pred);
			end
			if (report_valid && !report_stall) begin
				got = report_word;
				if (pending_reports.size() == 0) begin
					error_count++;
					if (error_count <= SHOW_LIMIT)
						$display("%0t: report word with nothing pending: %p", $realtime, got);
				end else begin
					want = pending_reports.pop_front();
					if (got.rotation !== want.rotation)
						report_error("rotation", want.rotation, got.rotation);
					if (got.button_event !== want.button_event)
						report_error("button_event", want.button_event, got.button_event);
					if (got.button_released !== want.button_released)
						report_error("button_released", want.button_released,
							got.button_released);
				end
			end
		end
	end

	// Watchdog: end the run if the stimulus or the reports hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int k;
		int p;
		int mode;
		poll_row_t row;

		// Reset state: AB at 11, accumulator 0, switch released, stamp 0,
		// four transitions per click, 20 ms debounce.
		add_row(1, 1, 1, 32'd0, 1);                        // no movement, no event
		add_row(0, 1, 1, 32'd1, 0);                        // clockwise run 11-01-00-10-11
		add_row(0, 0, 1, 32'd2, 0);
		add_row(1, 0, 1, 32'd3, 0);
		add_row(1, 1, 1, 32'd4, 1, ROT_CW);                // fourth step makes a click
		add_row(1, 0, 1, 32'd5, 0);                        // counter-clockwise run
		add_row(0, 0, 1, 32'd6, 0);
		add_row(0, 1, 1, 32'd7, 0);
		add_row(1, 1, 1, 32'd9, 1, ROT_CCW);
		add_row(0, 0, 1, 32'd10, 1);                       // both channels flip: ignored
		add_row(1, 1, 1, 32'd11, 1);
		add_row(1, 1, 0, 32'd100, 1);                      // press starts the debounce
		add_row(1, 1, 0, 32'd119, 0);                      // one ms short
		add_row(1, 1, 0, 32'd120, 1, ROT_NONE, BTN_PRESS, 1'b0);
		add_row(1, 1, 1, 32'd130, 0);                      // bounce up, then back down
		add_row(1, 1, 0, 32'd135, 0);
		add_row(1, 1, 0, 32'd400, 0);
		add_row(1, 1, 1, 32'hFFFF_FFF0, 0);                // release just before the wrap
		add_row(1, 1, 1, 32'hFFFF_FFFF, 0);
		add_row(1, 1, 1, 32'h0000_0004, 1, ROT_NONE, BTN_RELEASE, 1'b1);
		add_row(0, 1, 1, 32'd5, 0);                        // one step forward, one back
		add_row(1, 1, 1, 32'd6, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table at the reset settings, no idling.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_poll(row.word, row.typed, row.rep);
		end

		// Random passes, each with fresh register settings and idling mode.
		for (p = 0; p < PASS_COUNT; p++) begin
			poll_valid <= 1'b0;
			send_pct <= 0;
			stall_pct <= 0;
			drain_reports();
			// junk in the upper data bits must not reach the 4-bit detent field
			write_reg(CFG_DETENT, {12'($urandom), 4'(PASS_DETENT[p])});
			write_reg(CFG_DEBOUNCE, 16'(PASS_DEBOUNCE[p]));
			cfg_valid <= 1'b0;
			stim_deb = PASS_DEBOUNCE[p];
			stim_now = (p == 3) ? 32'hFFFF_FC00 : $urandom;
			mode = PASS_MODE[p];
			send_pct <= (mode == 1) ? 52 : (mode == 3) ? 7 : 0;
			stall_pct <= (mode == 2) ? 52 : (mode == 3) ? 7 : 0;
			for (k = 0; k < ITEMS_PER_PASS; k++) begin
				if (k == ITEMS_PER_PASS / 2) begin
					// hold the sender off until every report is back
					poll_valid <= 1'b0;
					drain_reports();
				end
				send_poll(next_poll(), 1'b0, '0);
			end
		end

		poll_valid <= 1'b0;
		drain_reports();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
